/* hdl/msm_pkg.sv */
// ----------------------------------------------------------------------------
// msm_pkg: shared constants and types for the multichannel sliding median
// Window geometry, field widths and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package msm_pkg;

    // Geometry
    localparam int CHANNELS      = 8;
    localparam int WINDOW_LENGTH = 10;
    localparam int MEDIAN_IDX    = WINDOW_LENGTH / 2;

    // Field widths
    localparam int CH_W  = 3;
    localparam int SMP_W = 16;

    // Derived widths
    localparam int IDX_W   = $clog2(WINDOW_LENGTH);
    localparam int CNT_W   = $clog2(WINDOW_LENGTH + 1);
    localparam int DEPTH   = CHANNELS * WINDOW_LENGTH;
    localparam int ADDR_W  = $clog2(DEPTH);

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic write;     // store sample, advance pointer and fill count
        logic rd_en;     // issue a window read
        t_idx rd_idx;    // window entry to read
        logic load_out;  // load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic raw;       // request passes straight through (warm-up or bad channel)
        logic out_free;  // result register can take a new value this cycle
    } t_sts;

endpackage

/* hdl/msm_ram.sv */
// ----------------------------------------------------------------------------
// msm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module msm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/msm_ctrl.sv */
// ----------------------------------------------------------------------------
// msm_ctrl: sequencer for the sliding median
// Accepts a request, has it stored, walks the window read addresses and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module msm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  msm_pkg::t_sts i_sts,
    output msm_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WRITE  = 5'b00010,
        S_READ   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    msm_pkg::t_idx r_rd_idx;
    msm_pkg::t_idx n_rd_idx;

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_rd_idx = r_rd_idx;
        o_cmd    = '0;
        o_cmd.rd_idx = r_rd_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_rd_idx    = '0;
                n_state     = i_sts.raw ? S_FINISH : S_READ;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                if (r_rd_idx == msm_pkg::t_idx'(msm_pkg::WINDOW_LENGTH - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                // last read word lands in its lane
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* hdl/msm_dp.sv */
// ----------------------------------------------------------------------------
// msm_dp: datapath for the sliding median
// Per-channel pointers and fill counts, the window RAM, ten ranking lanes
// and the result register.
// ----------------------------------------------------------------------------
module msm_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [msm_pkg::CH_W-1:0]           i_channel,
    input  logic signed [msm_pkg::SMP_W-1:0]   i_sample,
    input  msm_pkg::t_cmd                      i_cmd,
    output msm_pkg::t_sts                      o_sts,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [msm_pkg::SMP_W-1:0]   o_filtered
);

    // Captured request
    logic [msm_pkg::CH_W-1:0]         r_ch;
    logic signed [msm_pkg::SMP_W-1:0] r_smp;
    logic                             r_raw;

    // Per-channel state
    msm_pkg::t_idx r_ptr  [msm_pkg::CHANNELS];
    msm_pkg::t_cnt r_fill [msm_pkg::CHANNELS];

    logic          in_range;
    msm_pkg::t_idx cur_ptr;
    msm_pkg::t_cnt cur_fill;
    logic          warm;

    // RAM side
    msm_pkg::t_addr             base_addr;
    msm_pkg::t_addr             waddr;
    msm_pkg::t_addr             raddr;
    logic                       we;
    logic [msm_pkg::SMP_W-1:0]  rdata;
    logic                       r_ld_en;
    msm_pkg::t_idx              r_ld_idx;

    // Ranking lanes
    logic signed [msm_pkg::SMP_W-1:0] r_val  [msm_pkg::WINDOW_LENGTH];
    logic signed [msm_pkg::SMP_W-1:0] n_val  [msm_pkg::WINDOW_LENGTH];
    msm_pkg::t_idx                    r_rank [msm_pkg::WINDOW_LENGTH];
    msm_pkg::t_idx                    n_rank [msm_pkg::WINDOW_LENGTH];
    logic signed [msm_pkg::SMP_W-1:0] ld_val;
    msm_pkg::t_idx                    ld_cnt;
    logic signed [msm_pkg::SMP_W-1:0] median;

    // Result register
    logic                             r_out_valid;
    logic signed [msm_pkg::SMP_W-1:0] r_filtered;

    // Capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch  <= i_channel;
            r_smp <= i_sample;
        end
        if (i_cmd.write) begin
            r_raw <= o_sts.raw;
        end
    end

    // Channel lookup
    assign in_range = ({1'b0, r_ch} < (msm_pkg::CH_W + 1)'(msm_pkg::CHANNELS));
    assign cur_ptr  = r_ptr[r_ch];
    assign cur_fill = r_fill[r_ch];
    assign warm     = (cur_fill < msm_pkg::t_cnt'(msm_pkg::WINDOW_LENGTH));

    // Pointer and fill count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < msm_pkg::CHANNELS; c++) begin
                r_ptr[c]  <= '0;
                r_fill[c] <= '0;
            end
        end else if (i_cmd.write && in_range) begin
            if (cur_ptr == msm_pkg::t_idx'(msm_pkg::WINDOW_LENGTH - 1)) begin
                r_ptr[r_ch] <= '0;
            end else begin
                r_ptr[r_ch] <= cur_ptr + 1'b1;
            end
            if (warm) begin
                r_fill[r_ch] <= cur_fill + 1'b1;
            end
        end
    end

    // Window RAM addressing: channel row plus entry
    assign base_addr = msm_pkg::t_addr'(r_ch) * msm_pkg::t_addr'(msm_pkg::WINDOW_LENGTH);
    assign waddr     = base_addr + msm_pkg::t_addr'(cur_ptr);
    assign raddr     = base_addr + msm_pkg::t_addr'(i_cmd.rd_idx);
    assign we        = i_cmd.write && in_range;

    msm_ram #(
        .WIDTH (msm_pkg::SMP_W),
        .DEPTH (msm_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_smp),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Read data comes from the RAM's output register; enable and index are delayed to match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_en <= 1'b0;
        end else begin
            r_ld_en <= i_cmd.rd_en;
        end
        r_ld_idx <= i_cmd.rd_idx;
    end

    // Incremental ranking: each arriving word bumps the rank of every
    // earlier lane holding a larger value, and takes as its own rank the
    // number of earlier lanes not above it (ties go to the earlier lane).
    assign ld_val = $signed(rdata);

    always_comb begin
        n_val  = r_val;
        n_rank = r_rank;
        ld_cnt = '0;
        if (r_ld_en) begin
            for (int i = 0; i < msm_pkg::WINDOW_LENGTH; i++) begin
                if (i < int'(r_ld_idx)) begin
                    if (ld_val < r_val[i]) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end else begin
                        ld_cnt = ld_cnt + 1'b1;
                    end
                end
            end
            n_val[r_ld_idx]  = ld_val;
            n_rank[r_ld_idx] = ld_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_rank <= n_rank;
    end

    // Median pick: the lane ranked at the middle position
    always_comb begin
        median = r_val[0];
        for (int i = 0; i < msm_pkg::WINDOW_LENGTH; i++) begin
            if (r_rank[i] == msm_pkg::t_idx'(msm_pkg::MEDIAN_IDX)) begin
                median = r_val[i];
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_filtered <= r_raw ? r_smp : median;
        end
    end

    // Status
    assign o_sts.raw      = !in_range || warm;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

endmodule

/* hdl/multichannel_sliding_median.sv */
// ----------------------------------------------------------------------------
// multichannel_sliding_median: per-channel sliding-window median filter
// Ten-sample window per channel, upper median, raw pass-through in warm-up.
// ----------------------------------------------------------------------------
// Each request carries a channel and a signed sample; exactly one result
// comes back per request, in order. The first ten samples of a channel, and
// any request on a channel number at or above the channel count, return the
// raw sample by way of the write and finish states. Once a channel's window
// is full a request passes the write, read, drain and finish states: the ten
// window entries are read from the single read port of the window RAM one a
// cycle and ranked as they arrive, then the middle-ranked entry is picked.
// Requests are taken one at a time; a finished result waits in its own
// register, so the next request can be accepted before the previous result
// has been taken. No clearing pass is needed after reset.
module multichannel_sliding_median (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [msm_pkg::CH_W-1:0]         i_channel,
    input  logic signed [msm_pkg::SMP_W-1:0] i_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [msm_pkg::SMP_W-1:0] o_filtered
);

    msm_pkg::t_cmd cmd;
    msm_pkg::t_sts sts;

    // Sequencer
    msm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    msm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_channel   (i_channel),
        .i_sample    (i_sample),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_filtered  (o_filtered)
    );

    // An accepted request is stored in the very next cycle
    a_accept_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> cmd.write)
        else $error("accepted request not written next cycle");

    // The result register is never overwritten while it still holds a result
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending result");

    // Window reads walk the entries in order, one per cycle
    a_read_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rd_en && $past(cmd.rd_en)) |-> (cmd.rd_idx == $past(cmd.rd_idx) + 1'b1))
        else $error("window read index skipped");

    // No input is taken while a window read is in flight
    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_en |-> !o_in_ready)
        else $error("request accepted during window read");

endmodule

/* tb/msm_median_checker.sv */
// ----------------------------------------------------------------------------
// msm_median_checker: result checker for the multichannel sliding median
// Watches both handshakes of the filter, keeps its own per-channel windows,
// pointers and fill counts, predicts the filtered value of every accepted
// request and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module msm_median_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [msm_pkg::CH_W-1:0]         i_channel,
    input  logic signed [msm_pkg::SMP_W-1:0] i_sample,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [msm_pkg::SMP_W-1:0] i_filtered,
    output int                               o_fail_count,
    output int                               o_pending
);
    import msm_pkg::*;

    typedef logic signed [SMP_W-1:0] t_smp;

    // Shadow of the filter state
    t_smp window_mem [CHANNELS][WINDOW_LENGTH];
    int   wr_ptr     [CHANNELS];
    int   fill_level [CHANNELS];

    // Filtered values still owed by the block, oldest first
    t_smp filtered_due [$];
    int   fail_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_total   = 0;
    end

    // Upper median of one channel's window, ranked by signed value
    function automatic t_smp window_median(input int ch);
        t_smp ranked [WINDOW_LENGTH];
        t_smp key;
        int   b;
        for (int a = 0; a < WINDOW_LENGTH; a++) ranked[a] = window_mem[ch][a];
        for (int a = 1; a < WINDOW_LENGTH; a++) begin
            key = ranked[a];
            b   = a;
            while (b > 0 && ranked[b-1] > key) begin
                ranked[b] = ranked[b-1];
                b--;
            end
            ranked[b] = key;
        end
        return ranked[MEDIAN_IDX];
    endfunction

    // Store the sample and work out what the block should return for it
    function automatic t_smp filter_step(input int ch, input t_smp smp);
        if (ch >= CHANNELS) return smp;
        window_mem[ch][wr_ptr[ch]] = smp;
        wr_ptr[ch] = (wr_ptr[ch] + 1 >= WINDOW_LENGTH) ? 0 : wr_ptr[ch] + 1;
        if (fill_level[ch] < WINDOW_LENGTH) begin
            fill_level[ch]++;
            return smp;
        end
        return window_median(ch);
    endfunction

    always @(posedge i_clk) begin
        t_smp want;
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int k = 0; k < WINDOW_LENGTH; k++) window_mem[c][k] = '0;
                wr_ptr[c]     = 0;
                fill_level[c] = 0;
            end
            filtered_due.delete();
        end else begin
            // result side first: a request accepted now cannot be answered now
            if (i_out_valid && i_out_ready) begin
                if (filtered_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result %0d with no request outstanding",
                                 $realtime, i_filtered);
                end else begin
                    want = filtered_due.pop_front();
                    if (i_filtered !== want) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%0t: filtered mismatch, expected %0d, got %0d",
                                     $realtime, want, i_filtered);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                filtered_due.push_back(filter_step(int'(i_channel), i_sample));
        end
        o_fail_count <= fail_total;
        o_pending    <= filtered_due.size();
    end

endmodule

/* tb/multichannel_sliding_median_test.sv */
// ----------------------------------------------------------------------------
// multichannel_sliding_median_test: testbench top for the median filter
// Drives requests through the valid/ready input with a directed warm-up and
// median sequence, then random traffic in phases of sender idling and
// receiver stalling, including a long receiver hold-off and a full drain.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module multichannel_sliding_median_test;
    import msm_pkg::*;

    typedef logic signed [SMP_W-1:0] t_smp;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    logic [CH_W-1:0]  i_channel   = '0;
    t_smp             i_sample    = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_smp             o_filtered;

    int fail_count;
    int pending;

    // Idling controls
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_token    = 0;

    // Per-channel level that random samples cluster around
    t_smp level [CHANNELS];

    always #2 i_clk = ~i_clk;

    multichannel_sliding_median u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_channel   (i_channel),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (o_filtered)
    );

    msm_median_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_channel    (i_channel),
        .i_sample     (i_sample),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_filtered   (o_filtered),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stalls, plus a long hold-off whenever the token moves
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= 300;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one request, idling first at the current sender rate
    task automatic send_req(input int ch, input t_smp smp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_channel  <= CH_W'(ch);
        i_sample   <= smp;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop offering and wait for every owed result
    task automatic drain;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Random sample: full range, clustered, extremes or a repeated level
    function automatic t_smp pick_sample(input int ch);
        case ($urandom_range(5))
            0, 1: return t_smp'($urandom);
            2, 3: return level[ch] + t_smp'($urandom_range(64)) - t_smp'(32);
            4:    return ($urandom_range(1) != 0) ? t_smp'(16'h7FFF) : t_smp'(16'h8000);
            default: return level[ch];
        endcase
    endfunction

    task automatic random_burst(input int count);
        int ch;
        for (int n = 0; n < count; n++) begin
            ch = $urandom_range(CHANNELS - 1);
            if ($urandom_range(15) == 0) level[ch] = t_smp'($urandom);
            send_req(ch, pick_sample(ch));
        end
    endtask

    initial begin
        for (int c = 0; c < CHANNELS; c++) level[c] = t_smp'($urandom);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: warm-up of channel 0 with extremes, last warm-up sample
        // returned raw, then medians including ties
        send_req(0, -16'sd32768);
        send_req(0, 16'sd32767);
        send_req(0, 16'sd0);
        send_req(0, -16'sd1);
        send_req(0, 16'sd1);
        send_req(0, 16'sh4000);
        send_req(0, -16'sh4000);
        send_req(0, 16'sd100);
        send_req(0, -16'sd100);
        send_req(0, 16'sd32767);
        send_req(0, -16'sd32768);
        send_req(0, 16'sd5);
        send_req(0, 16'sd5);
        send_req(0, 16'sd5);
        send_req(0, 16'sd5);
        send_req(0, 16'sd5);
        // other channels keep separate windows
        send_req(7, 16'sh5555);
        send_req(7, -16'sh5556);
        send_req(3, 16'sd32767);
        send_req(1, -16'sd32768);
        send_req(0, 16'sd5);
        drain();

        // Phase: no idling, with a long receiver hold-off to back the block up
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_token   <= hold_token + 1;
        random_burst(220);

        // Phase: sender idle most of the time, with a full drain midway
        send_idle_pct = 71;
        stall_pct    <= 0;
        random_burst(100);
        drain();
        random_burst(100);

        // Phase: receiver stalling most of the time
        send_idle_pct = 0;
        stall_pct    <= 71;
        random_burst(210);

        // Phase: both sides idling now and then
        send_idle_pct = 23;
        stall_pct    <= 23;
        random_burst(210);

        drain();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/msm_pkg.sv
hdl/msm_ram.sv
hdl/msm_ctrl.sv
hdl/msm_dp.sv
hdl/multichannel_sliding_median.sv
tb/msm_median_checker.sv
tb/multichannel_sliding_median_test.sv
